@@ hw/rtl/pcmp_pkg.sv @@
// Package with the shared widths, the prime and the modular add for the partition counter.
`timescale 1ns / 1ps

package pcmp_pkg;

  localparam int WAYS_W = 30;
  localparam int IN_W   = 10;

  localparam logic [WAYS_W-1:0] PRIME = 30'd1000000007;

  // Both operands are already below the prime, so one conditional subtract suffices.
  function automatic logic [WAYS_W-1:0] add_mod(input logic [WAYS_W-1:0] a,
                                                input logic [WAYS_W-1:0] b);
    logic [WAYS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[WAYS_W-1:0];
  endfunction

endpackage

@@ hw/rtl/pcmp_table.sv @@
// Working table: one write port, two registered read ports with write-to-read forwarding.
`timescale 1ns / 1ps

module pcmp_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [pcmp_pkg::WAYS_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_hi_addr,
  input  logic [AW-1:0]               rd_lo_addr,
  output logic [pcmp_pkg::WAYS_W-1:0] rd_hi_data,
  output logic [pcmp_pkg::WAYS_W-1:0] rd_lo_data
);

  logic [pcmp_pkg::WAYS_W-1:0] mem [DEPTH];
  logic [pcmp_pkg::WAYS_W-1:0] hi_q;
  logic [pcmp_pkg::WAYS_W-1:0] lo_q;
  logic [pcmp_pkg::WAYS_W-1:0] fwd_data;
  logic                        hi_fwd;
  logic                        lo_fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hi_q <= mem[rd_hi_addr];
      lo_q <= mem[rd_lo_addr];
    end
    fwd_data <= wr_data;
  end

  // A read issued in the same cycle as a write to that entry would see the old contents;
  // the write data is registered and used in its place.
  always_ff @(posedge clk) begin
    if (rst) begin
      hi_fwd <= 1'b0;
      lo_fwd <= 1'b0;
    end else if (rd_en) begin
      hi_fwd <= wr_en && (wr_addr == rd_hi_addr);
      lo_fwd <= wr_en && (wr_addr == rd_lo_addr);
    end
  end

  assign rd_hi_data = hi_fwd ? fwd_data : hi_q;
  assign rd_lo_data = lo_fwd ? fwd_data : lo_q;

  a_fwd_needs_write: assert property (@(posedge clk) disable iff (rst)
    rd_en && wr_en && (wr_addr == rd_lo_addr) |=> lo_fwd)
    else $error("lower read port missed a forward");

  a_fwd_data_tracks: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> fwd_data == $past(wr_data))
    else $error("forward register lost write data");

  a_no_spurious_fwd: assert property (@(posedge clk) disable iff (rst)
    rd_en && !wr_en |=> !hi_fwd && !lo_fwd)
    else $error("forward set with no write");

endmodule

@@ hw/rtl/partition_count_mod_prime.sv @@
// Top level: partition counter modulo 1000000007, bottom-up table sweep per query.
//
//  channel  | dir | fields (low bit up)                          | handshake
//  ---------+-----+----------------------------------------------+------------------
//  s_*      | in  | tdata: total[9:0], largest_part[19:10], pad  | s_tvalid/s_tready
//  m_*      | out | tdata: ways[29:0], pad                       | m_tvalid/m_tready
//
// One table entry is cleared or updated per cycle through the single write port.
// Reset returns the control to idle and drops any pending result; the table needs no clear.
// A new query is taken only while idle; a finished result waits in the output register
// and a stalled m_tready holds the block in its final state until the transfer completes.
`timescale 1ns / 1ps

module partition_count_mod_prime #(
  parameter int MAX_TOTAL = 1023
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // total[9:0], largest_part[19:10], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // ways[29:0], zero pad
);

  localparam int DEPTH = MAX_TOTAL + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = AW + pcmp_pkg::IN_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]                  state;
  logic [AW-1:0]               n;
  logic [AW-1:0]               m;
  logic [AW-1:0]               j;
  logic [AW-1:0]               k;
  logic                        upd_valid;
  logic [AW-1:0]               upd_addr;
  logic [pcmp_pkg::WAYS_W-1:0] res;
  logic [pcmp_pkg::WAYS_W-1:0] ways_q;

  logic [XW-1:0]               tot_x;
  logic [XW-1:0]               part_x;
  logic [XW-1:0]               tot_c;
  logic [XW-1:0]               part_c;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [pcmp_pkg::WAYS_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_lo_addr;
  logic [pcmp_pkg::WAYS_W-1:0] rd_hi_data;
  logic [pcmp_pkg::WAYS_W-1:0] rd_lo_data;

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {2'b00, ways_q};

  // Saturate the total to the table size, then clamp the part bound to the total.
  always_comb begin
    tot_x  = XW'(s_tdata[9:0]);
    part_x = XW'(s_tdata[19:10]);
    tot_c  = (tot_x > XW'(MAX_TOTAL)) ? XW'(MAX_TOTAL) : tot_x;
    part_c = (part_x > tot_c) ? tot_c : part_x;
  end

  assign rd_en      = (state == S_RUN);
  assign rd_lo_addr = j - k;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j;
    wr_data = '0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_data = (j == '0) ? pcmp_pkg::WAYS_W'(1) : '0;
    end else if (upd_valid) begin
      wr_en   = 1'b1;
      wr_addr = upd_addr;
      wr_data = pcmp_pkg::add_mod(rd_hi_data, rd_lo_data);
    end
  end

  pcmp_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_hi_addr (j),
    .rd_lo_addr (rd_lo_addr),
    .rd_hi_data (rd_hi_data),
    .rd_lo_data (rd_lo_data)
  );

  // The last entry written is always entry n, so it is the answer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      res <= wr_data;
    end
    upd_addr <= j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      upd_valid <= 1'b0;
      m_tvalid  <= 1'b0;
      n         <= '0;
      m         <= '0;
      j         <= '0;
      k         <= '0;
      ways_q    <= '0;
    end else begin
      upd_valid <= (state == S_RUN);
      // In the final state a completed transfer is replaced by the new result below.
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            n     <= tot_c[AW-1:0];
            m     <= part_c[AW-1:0];
            j     <= '0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (j == n) begin
            if (m == '0) begin
              state <= S_FINISH;
            end else begin
              k     <= AW'(1);
              j     <= AW'(1);
              state <= S_RUN;
            end
          end else begin
            j <= j + AW'(1);
          end
        end
        S_RUN: begin
          if (j == n) begin
            if (k == m) begin
              state <= S_DRAIN;
            end else begin
              k <= k + AW'(1);
              j <= k + AW'(1);
            end
          end else begin
            j <= j + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            ways_q   <= res;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_upd_after_run: assert property (@(posedge clk) disable iff (rst)
    upd_valid |-> $past(state) == S_RUN)
    else $error("table update outside a sweep");

  a_run_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> (k != '0) && (k <= m) && (j >= k) && (j <= n) && (m <= n))
    else $error("sweep indexes out of range");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ways_q < pcmp_pkg::PRIME)
    else $error("result not reduced modulo the prime");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !upd_valid || $past(state) == S_RUN)
    else $error("update pending while idle");

endmodule
